// File: rtl/core/sbpm_pkg.sv
// shared constants, codes and control types for the statistics buffer pool manager
`timescale 1ns / 1ps
`default_nettype none

package sbpm_pkg;

    // default sizing
    localparam int DEF_POOL_DEPTH  = 8;
    localparam int DEF_FRAME_WIDTH = 16;

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int TAG_W  = 32;
    localparam int WRAP_W = 16;
    localparam int BIU_W  = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_NEXT       = 3'd0;
    localparam logic [OP_W-1:0] OP_QUEUE      = 3'd1;
    localparam logic [OP_W-1:0] OP_GET        = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE    = 3'd3;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ACTIVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WRAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFS_USED  = 1'd1;

    // configuration reset values
    localparam logic [WRAP_W-1:0] WRAP_RESET = 16'hFFFF;
    localparam logic [BIU_W-1:0]  BIU_RESET  = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted item, rewind the scan
        logic step;    // evaluate one pool entry
        logic commit;  // apply the operation and load the result register
    } sbpm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;  // current step is the last one of the scan
    } sbpm_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sbpm_ctrl.sv
// controller state machine: item handshake and scan sequencing
`timescale 1ns / 1ps
`default_nettype none

module sbpm_ctrl
    import sbpm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire sbpm_stat_t stat,
    output sbpm_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sbpm_datapath.sv
// datapath: pool entries, active/lock tracking, frame counter, scan and result register
`timescale 1ns / 1ps
`default_nettype none

module sbpm_datapath
    import sbpm_pkg::*;
#(
    parameter int POOL_DEPTH  = DEF_POOL_DEPTH,
    parameter int FRAME_WIDTH = DEF_FRAME_WIDTH,
    localparam int IDX_W = $clog2(POOL_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sbpm_cmd_t              cmd,
    output sbpm_stat_t                  stat,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wr_data,
    input  wire logic [OP_W-1:0]        s_opcode,
    input  wire logic [FRAME_WIDTH-1:0] s_requested_frame,
    input  wire logic [TAG_W-1:0]       s_config_tag_in,
    output logic [STAT_W-1:0]           m_status,
    output logic [IDX_W-1:0]            m_buffer_index,
    output logic [FRAME_WIDTH-1:0]      m_frame_tag,
    output logic [TAG_W-1:0]            m_config_tag_out
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int NW    = (CNT_W > BIU_W) ? CNT_W : BIU_W;
    localparam int CMP_W = (FRAME_WIDTH > WRAP_W) ? FRAME_WIDTH : WRAP_W;
    localparam int DW    = CMP_W + 2;

    // configuration
    logic [WRAP_W-1:0] wrap_limit_reg;
    logic [BIU_W-1:0]  biu_reg;

    // pool storage
    logic [POOL_DEPTH-1:0]  valid_reg, valid_next;
    logic [FRAME_WIDTH-1:0] entry_frame [POOL_DEPTH];
    logic [TAG_W-1:0]       entry_config [POOL_DEPTH];
    logic                   entry_wr_en;

    // pool control state
    logic                   active_present_reg, active_present_next;
    logic [IDX_W-1:0]       active_slot_reg, active_slot_next;
    logic                   locked_present_reg, locked_present_next;
    logic [IDX_W-1:0]       locked_slot_reg, locked_slot_next;
    logic [FRAME_WIDTH-1:0] frame_counter_reg, frame_counter_next;

    // captured item
    logic [OP_W-1:0]        op_reg;
    logic [FRAME_WIDTH-1:0] req_reg;
    logic [TAG_W-1:0]       tag_reg;

    // scan state
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic                   pick_valid_reg, pick_valid_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [FRAME_WIDTH-1:0] best_frame_reg, best_frame_next;
    logic [TAG_W-1:0]       best_cfg_reg, best_cfg_next;

    // result register
    logic [STAT_W-1:0]      status_reg, status_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic [FRAME_WIDTH-1:0] ftag_reg, ftag_next;
    logic [TAG_W-1:0]       ctag_reg, ctag_next;

    // scan helpers
    logic [NW-1:0]          biu_ext, depth_n, n_eff, idx_ext;
    logic                   in_range, last_idx, scanning_op, brk;
    logic                   cur_valid;
    logic [FRAME_WIDTH-1:0] cur_frame;
    logic [TAG_W-1:0]       cur_cfg;
    logic                   skip_locked, skip_active;

    // wraparound age compare of the current entry against the best so far
    logic [DW-1:0]          a_ext, b_ext;
    logic signed [DW-1:0]   d_ba, d_ab, half_s;
    logic                   cur_later;

    // frame counter advance
    logic [FRAME_WIDTH-1:0] cnt_inc;
    logic                   wrap_hit;

    assign biu_ext = NW'(biu_reg);
    assign depth_n = NW'(POOL_DEPTH);
    assign n_eff   = (biu_ext > depth_n) ? depth_n : biu_ext;
    assign idx_ext = NW'(scan_idx_reg);
    assign in_range = idx_ext < n_eff;
    assign last_idx = (idx_ext + NW'(1)) >= n_eff;

    assign cur_valid = valid_reg[scan_idx_reg];
    assign cur_frame = entry_frame[scan_idx_reg];
    assign cur_cfg   = entry_config[scan_idx_reg];

    assign skip_locked = locked_present_reg && (locked_slot_reg == scan_idx_reg);
    assign skip_active = active_present_reg && (active_slot_reg == scan_idx_reg);
    assign scanning_op = (op_reg == OP_NEXT) || (op_reg == OP_GET);

    assign a_ext  = DW'(cur_frame);
    assign b_ext  = DW'(best_frame_reg);
    assign d_ba   = b_ext - a_ext;
    assign d_ab   = a_ext - b_ext;
    assign half_s = DW'(wrap_limit_reg >> 1);

    always_comb begin
        if (d_ba > half_s) begin
            cur_later = 1'b1;
        end else if (d_ab > half_s) begin
            cur_later = 1'b0;
        end else begin
            cur_later = cur_frame > best_frame_reg;
        end
    end

    assign cnt_inc  = frame_counter_reg + FRAME_WIDTH'(1);
    assign wrap_hit = CMP_W'(cnt_inc) == CMP_W'(wrap_limit_reg);

    // scan step
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        pick_valid_next = pick_valid_reg;
        pick_next       = pick_reg;
        best_frame_next = best_frame_reg;
        best_cfg_next   = best_cfg_reg;
        brk             = 1'b0;
        if (cmd.load) begin
            scan_idx_next   = '0;
            found_next      = 1'b0;
            pick_valid_next = 1'b0;
            pick_next       = '0;
        end else if (cmd.step) begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            if (in_range && (op_reg == OP_NEXT) && !skip_locked) begin
                if (!cur_valid) begin
                    // unused buffer wins outright
                    found_next      = 1'b1;
                    pick_next       = scan_idx_reg;
                    pick_valid_next = 1'b0;
                    brk             = 1'b1;
                end else if (!found_reg || !cur_later) begin
                    found_next      = 1'b1;
                    pick_next       = scan_idx_reg;
                    pick_valid_next = 1'b1;
                    best_frame_next = cur_frame;
                    best_cfg_next   = cur_cfg;
                end
            end else if (in_range && (op_reg == OP_GET) && !skip_active && cur_valid
                         && (cur_frame == req_reg)) begin
                found_next      = 1'b1;
                pick_next       = scan_idx_reg;
                pick_valid_next = 1'b1;
                best_frame_next = cur_frame;
                best_cfg_next   = cur_cfg;
                brk             = 1'b1;
            end
        end
    end

    assign stat.scan_done = !scanning_op || last_idx || brk;

    // operation commit
    always_comb begin
        valid_next          = valid_reg;
        active_present_next = active_present_reg;
        active_slot_next    = active_slot_reg;
        locked_present_next = locked_present_reg;
        locked_slot_next    = locked_slot_reg;
        frame_counter_next  = frame_counter_reg;
        entry_wr_en         = 1'b0;
        status_next         = status_reg;
        index_next          = index_reg;
        ftag_next           = ftag_reg;
        ctag_next           = ctag_reg;
        if (cmd.commit) begin
            status_next = ST_OK;
            index_next  = '0;
            ftag_next   = '0;
            ctag_next   = '0;
            unique case (op_reg)
                OP_NEXT: begin
                    active_present_next = found_reg;
                    active_slot_next    = found_reg ? pick_reg : '0;
                    if (found_reg) begin
                        index_next = pick_reg;
                        if (pick_valid_reg) begin
                            ftag_next = best_frame_reg;
                            ctag_next = best_cfg_reg;
                        end
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                OP_QUEUE: begin
                    if (!active_present_reg) begin
                        status_next = ST_NO_ACTIVE;
                    end else begin
                        entry_wr_en                 = 1'b1;
                        valid_next[active_slot_reg] = 1'b1;
                        index_next                  = active_slot_reg;
                        ftag_next                   = frame_counter_reg;
                        ctag_next                   = tag_reg;
                        frame_counter_next          = wrap_hit ? '0 : cnt_inc;
                        active_present_next         = 1'b0;
                        active_slot_next            = '0;
                    end
                end
                OP_GET: begin
                    if (found_reg) begin
                        locked_present_next = 1'b1;
                        locked_slot_next    = pick_reg;
                        index_next          = pick_reg;
                        ftag_next           = best_frame_reg;
                        ctag_next           = best_cfg_reg;
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                OP_RELEASE: begin
                    locked_present_next = 1'b0;
                    locked_slot_next    = '0;
                end
                OP_INVALIDATE: begin
                    valid_next          = '0;
                    active_present_next = 1'b0;
                    active_slot_next    = '0;
                end
                default: begin
                    // unused opcodes leave the pool alone
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_limit_reg     <= WRAP_RESET;
            biu_reg            <= BIU_RESET;
            valid_reg          <= '0;
            active_present_reg <= 1'b0;
            active_slot_reg    <= '0;
            locked_present_reg <= 1'b0;
            locked_slot_reg    <= '0;
            frame_counter_reg  <= FRAME_WIDTH'(1);
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FRAME_WRAP: wrap_limit_reg <= cfg_wr_data[WRAP_W-1:0];
                    CFG_BUFS_USED:  biu_reg        <= cfg_wr_data[BIU_W-1:0];
                    default: begin
                    end
                endcase
            end
            valid_reg          <= valid_next;
            active_present_reg <= active_present_next;
            active_slot_reg    <= active_slot_next;
            locked_present_reg <= locked_present_next;
            locked_slot_reg    <= locked_slot_next;
            frame_counter_reg  <= frame_counter_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            req_reg <= s_requested_frame;
            tag_reg <= s_config_tag_in;
        end
        if (entry_wr_en) begin
            entry_frame[active_slot_reg]  <= frame_counter_reg;
            entry_config[active_slot_reg] <= tag_reg;
        end
        scan_idx_reg   <= scan_idx_next;
        found_reg      <= found_next;
        pick_valid_reg <= pick_valid_next;
        pick_reg       <= pick_next;
        best_frame_reg <= best_frame_next;
        best_cfg_reg   <= best_cfg_next;
        status_reg     <= status_next;
        index_reg      <= index_next;
        ftag_reg       <= ftag_next;
        ctag_reg       <= ctag_next;
    end

    assign m_status         = status_reg;
    assign m_buffer_index   = index_reg;
    assign m_frame_tag      = ftag_reg;
    assign m_config_tag_out = ctag_reg;

endmodule

`default_nettype wire

// File: rtl/core/stat_buffer_pool_manager.sv
// top level of the statistics buffer pool manager
// sequence: accept, then scan steps that each visit one pool entry (next and get walk up to
//   buffers_in_use entries, capped at the pool depth, stopping early on a hit; other opcodes
//   end the scan at once), then commit; the result is valid in the cycle after commit
// input: a new item is taken only once the previous one has committed; the scan is set by the
//   single compare unit that visits one entry per cycle
// reset: synchronous active-low aresetn clears the pool valid bits, active and lock, sets the
//   frame counter to 1 and the registers to their defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module stat_buffer_pool_manager
    import sbpm_pkg::*;
#(
    parameter int POOL_DEPTH  = DEF_POOL_DEPTH,
    parameter int FRAME_WIDTH = DEF_FRAME_WIDTH,
    localparam int IDX_W = $clog2(POOL_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wr_data,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [OP_W-1:0]        s_opcode,
    input  wire logic [FRAME_WIDTH-1:0] s_requested_frame,
    input  wire logic [TAG_W-1:0]       s_config_tag_in,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [STAT_W-1:0]           m_status,
    output logic [IDX_W-1:0]            m_buffer_index,
    output logic [FRAME_WIDTH-1:0]      m_frame_tag,
    output logic [TAG_W-1:0]            m_config_tag_out
);

    // command and status between sequencer and datapath
    sbpm_cmd_t  cmd;
    sbpm_stat_t stat;

    // sequencer: accepts an item when idle, walks the scan, commits when the
    // result register is free (a result may still wait while the next item scans)
    sbpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: pool entries, selection scan, frame counter and result register
    sbpm_datapath #(
        .POOL_DEPTH  (POOL_DEPTH),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_opcode          (s_opcode),
        .s_requested_frame (s_requested_frame),
        .s_config_tag_in   (s_config_tag_in),
        .m_status          (m_status),
        .m_buffer_index    (m_buffer_index),
        .m_frame_tag       (m_frame_tag),
        .m_config_tag_out  (m_config_tag_out)
    );

    // a commit never overwrites a result that has not been taken
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit while result register occupied");

    // a committed result shows up as valid on the next cycle
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("result lost after commit");

    // no new item is taken while one is in flight
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("request accepted during scan");

    // scan steps only run while the input side is closed
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !s_ready)
        else $error("scan step while idle");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the statistics buffer pool manager
`timescale 1ns / 1ps

module tb_top;
    import sbpm_pkg::*;

    localparam int POOL = DEF_POOL_DEPTH;
    localparam int FW   = DEF_FRAME_WIDTH;
    localparam int IW   = $clog2(POOL);

    // opcodes that the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_INVALIDATE + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

    // one result item as the block reports it
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IW-1:0]     index;
        logic [FW-1:0]     frame;
        logic [TAG_W-1:0]  ctag;
    } pool_result_t;

    // one row of the opening script; typed rows carry their result written out
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [FW-1:0]    frame;
        logic [TAG_W-1:0] tag;
        bit               typed;
        pool_result_t     want;
    } script_row_t;

    localparam pool_result_t NO_RESULT = '0;

    // clock, reset and ports
    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode;
    logic [FW-1:0]        s_requested_frame;
    logic [TAG_W-1:0]     s_config_tag_in;
    logic                 m_valid;
    logic                 m_ready;
    logic [STAT_W-1:0]    m_status;
    logic [IW-1:0]        m_buffer_index;
    logic [FW-1:0]        m_frame_tag;
    logic [TAG_W-1:0]     m_config_tag_out;

    always #5 aclk = ~aclk;

    stat_buffer_pool_manager dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_requested_frame (s_requested_frame),
        .s_config_tag_in   (s_config_tag_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_buffer_index    (m_buffer_index),
        .m_frame_tag       (m_frame_tag),
        .m_config_tag_out  (m_config_tag_out)
    );

    // ------------------------------------------------------------------
    // pool model: its own copy of the registers and the buffer state
    // ------------------------------------------------------------------
    logic [WRAP_W-1:0] wrap_limit_q;
    logic [BIU_W-1:0]  pool_size_q;
    bit                buf_live [POOL];
    logic [FW-1:0]     buf_frame [POOL];
    logic [TAG_W-1:0]  buf_ctag [POOL];
    bit                act_on;
    int                act_slot;
    bit                lock_on;
    int                lock_slot;
    logic [FW-1:0]     frame_count_q;

    pool_result_t awaited_results [$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    bit           calm = 1'b0;          // no random breaks on either side while set
    bit           hold_pending = 1'b1;  // one long receiver hold-off still to do

    function automatic void reset_pool_model();
        wrap_limit_q  = WRAP_RESET;
        pool_size_q   = BIU_RESET;
        for (int i = 0; i < POOL; i++) begin
            buf_live[i]  = 1'b0;
            buf_frame[i] = '0;
            buf_ctag[i]  = '0;
        end
        act_on        = 1'b0;
        act_slot      = 0;
        lock_on       = 1'b0;
        lock_slot     = 0;
        frame_count_q = 1;
    endfunction

    // a is later than b, with the distance window at half the wrap limit
    function automatic bit frame_newer(input logic [FW-1:0] a, input logic [FW-1:0] b);
        longint half;
        longint da;
        longint db;
        half = longint'(wrap_limit_q / 2);
        da   = a;
        db   = b;
        if (db - da > half) return 1'b1;
        if (da - db > half) return 1'b0;
        return da > db;
    endfunction

    // applies one operation to the model, returns the result it should produce
    function automatic pool_result_t apply_pool_op(input logic [OP_W-1:0] op,
                                                   input logic [FW-1:0] req,
                                                   input logic [TAG_W-1:0] tag);
        pool_result_t res;
        int  n;
        bit  found;
        int  pick;
        res   = '0;
        n     = (pool_size_q > POOL) ? POOL : int'(pool_size_q);
        found = 1'b0;
        pick  = 0;
        case (op)
            OP_NEXT: begin
                // unused buffer first, else the oldest; the locked one never
                for (int i = 0; i < n; i++) begin
                    if (lock_on && lock_slot == i) continue;
                    if (!buf_live[i]) begin
                        found = 1'b1;
                        pick  = i;
                        break;
                    end
                    if (!found || !frame_newer(buf_frame[i], buf_frame[pick])) begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                act_on   = found;
                act_slot = found ? pick : 0;
                if (found) begin
                    res.index = IW'(pick);
                    if (buf_live[pick]) begin
                        res.frame = buf_frame[pick];
                        res.ctag  = buf_ctag[pick];
                    end
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_QUEUE: begin
                if (!act_on) begin
                    res.status = ST_NO_ACTIVE;
                end else begin
                    buf_live[act_slot]  = 1'b1;
                    buf_frame[act_slot] = frame_count_q;
                    buf_ctag[act_slot]  = tag;
                    res.index = IW'(act_slot);
                    res.frame = frame_count_q;
                    res.ctag  = tag;
                    // counts modulo 2^FW, so a counter past a lowered limit runs on
                    frame_count_q = frame_count_q + 1'b1;
                    if (frame_count_q == wrap_limit_q) frame_count_q = '0;
                    act_on   = 1'b0;
                    act_slot = 0;
                end
            end
            OP_GET: begin
                for (int i = 0; i < n; i++) begin
                    if (act_on && act_slot == i) continue;
                    if (!buf_live[i]) continue;
                    if (buf_frame[i] == req) begin
                        found = 1'b1;
                        pick  = i;
                        break;
                    end
                end
                if (found) begin
                    // a new hit moves the lock
                    lock_on   = 1'b1;
                    lock_slot = pick;
                    res.index = IW'(pick);
                    res.frame = buf_frame[pick];
                    res.ctag  = buf_ctag[pick];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_RELEASE: begin
                lock_on   = 1'b0;
                lock_slot = 0;
            end
            OP_INVALIDATE: begin
                // the lock survives
                for (int i = 0; i < POOL; i++) buf_live[i] = 1'b0;
                act_on   = 1'b0;
                act_slot = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 29);
    endfunction

    // frame of some live buffer so that a get mostly hits
    function automatic logic [FW-1:0] pick_live_frame();
        int slot;
        slot = $urandom_range(0, POOL - 1);
        if (buf_live[slot] && $urandom_range(0, 7) != 0) return buf_frame[slot];
        return FW'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_op(input logic [OP_W-1:0] op, input logic [FW-1:0] frame,
                           input logic [TAG_W-1:0] tag, input bit typed,
                           input pool_result_t want);
        pool_result_t got;
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_opcode          <= op;
        s_requested_frame <= frame;
        s_config_tag_in   <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // item accepted at this edge
        got = apply_pool_op(op, frame, tag);
        awaited_results.push_back(typed ? want : got);
    endtask

    task automatic send_rand(input logic [OP_W-1:0] op, input logic [FW-1:0] frame);
        send_op(op, frame, pick_tag(), 1'b0, NO_RESULT);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // both registers, block idle
    task automatic load_pool_cfg(input logic [WRAP_W-1:0] wrap, input logic [BIU_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_FRAME_WRAP;
        cfg_wr_data <= CFG_W'(wrap);
        @(posedge aclk);
        cfg_index   <= CFG_BUFS_USED;
        // upper bits are don't care, toggle them anyway
        cfg_wr_data <= CFG_W'({$urandom_range(0, 4095), count});
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        wrap_limit_q = wrap;
        pool_size_q  = count;
    endtask

    // mostly next/queue pairs with gets in between, plus some noise
    task automatic run_pool_traffic(input int count);
        int sent;
        int roll;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            if (!paused && sent >= count / 2) begin
                // sender waits for the pipe to empty once per phase
                paused = 1'b1;
                drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                send_rand(OP_NEXT, FW'($urandom));
                sent++;
                if ($urandom_range(0, 3) == 0) begin
                    send_rand(OP_GET, pick_live_frame());
                    sent++;
                end
                send_rand(OP_QUEUE, FW'($urandom));
                sent++;
            end else if (roll < 70) begin
                send_rand(OP_GET, pick_live_frame());
                sent++;
                if ($urandom_range(0, 2) == 0) begin
                    send_rand(OP_RELEASE, FW'($urandom));
                    sent++;
                end
            end else if (roll < 78) begin
                send_rand(OP_RELEASE, FW'($urandom));
                sent++;
            end else if (roll < 82) begin
                send_rand(OP_INVALIDATE, FW'($urandom));
                sent++;
            end else if (roll < 87) begin
                send_rand(OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), FW'($urandom));
                sent++;
            end else begin
                // broken sequences: lone queue, blind get, lone next
                case ($urandom_range(0, 2))
                    0: send_rand(OP_QUEUE, FW'($urandom));
                    1: send_rand(OP_GET, FW'($urandom));
                    default: send_rand(OP_NEXT, FW'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // opening script
    // ------------------------------------------------------------------
    script_row_t opening_script [$];

    task automatic add_row(input logic [OP_W-1:0] op, input logic [FW-1:0] frame,
                           input logic [TAG_W-1:0] tag, input bit typed,
                           input logic [STAT_W-1:0] st, input logic [IW-1:0] idx,
                           input logic [FW-1:0] ftag, input logic [TAG_W-1:0] ctag);
        script_row_t row;
        row.op    = op;
        row.frame = frame;
        row.tag   = tag;
        row.typed = typed;
        row.want  = '{status: st, index: idx, frame: ftag, ctag: ctag};
        opening_script.push_back(row);
    endtask

    task automatic build_script();
        // after reset: nothing active, nothing stored
        add_row(OP_QUEUE,      16'h1234, 32'h0000_00FF, 1, ST_NO_ACTIVE, 0, 0, 0);
        add_row(OP_GET,        16'h0000, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(OP_RELEASE,    16'hFFFF, 32'h0000_0000, 1, ST_OK, 0, 0, 0);
        // fill two buffers, frames 1 and 2
        add_row(OP_NEXT,       16'h8000, 32'h8000_0000, 1, ST_OK, 0, 0, 0);
        add_row(OP_QUEUE,      16'h7FFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 1, 32'hFFFF_FFFF);
        add_row(OP_NEXT,       16'h0001, 32'h0000_0001, 1, ST_OK, 1, 0, 0);
        add_row(OP_QUEUE,      16'hAAAA, 32'h0000_0000, 1, ST_OK, 1, 2, 32'h0000_0000);
        // lock buffer 0, next skips it and the live buffer 1 for unused 2
        add_row(OP_GET,        16'h0001, 32'h5555_5555, 1, ST_OK, 0, 1, 32'hFFFF_FFFF);
        add_row(OP_NEXT,       16'h5555, 32'hAAAA_AAAA, 1, ST_OK, 2, 0, 0);
        // get while locked moves the lock
        add_row(OP_GET,        16'h0002, 32'h0F0F_0F0F, 1, ST_OK, 1, 2, 32'h0000_0000);
        add_row(OP_GET,        16'hFFFF, 32'hF0F0_F0F0, 1, ST_NOT_FOUND, 0, 0, 0);
        // ignored opcodes
        add_row(OP_UNUSED_LO,  16'hFFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 0);
        add_row(OP_W'(6),      16'h0000, 32'h0000_0000, 1, ST_OK, 0, 0, 0);
        add_row(OP_UNUSED_HI,  16'hFFFF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 0);
        // invalidate drops the active buffer, keeps the lock
        add_row(OP_INVALIDATE, 16'h00FF, 32'h00FF_00FF, 1, ST_OK, 0, 0, 0);
        add_row(OP_QUEUE,      16'hFF00, 32'hFF00_FF00, 1, ST_NO_ACTIVE, 0, 0, 0);
        add_row(OP_GET,        16'h0001, 32'h1111_1111, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(OP_NEXT,       16'h2222, 32'h2222_2222, 1, ST_OK, 0, 0, 0);
        add_row(OP_QUEUE,      16'h3333, 32'hA5A5_5A5A, 1, ST_OK, 0, 3, 32'hA5A5_5A5A);
        add_row(OP_RELEASE,    16'h4444, 32'h4444_4444, 1, ST_OK, 0, 0, 0);
        // left to the model
        add_row(OP_NEXT,       16'h6666, 32'h6666_6666, 0, 0, 0, 0, 0);
        add_row(OP_QUEUE,      16'h7777, 32'hDEAD_0001, 0, 0, 0, 0, 0);
        add_row(OP_GET,        16'h0003, 32'h8888_8888, 0, 0, 0, 0, 0);
        add_row(OP_NEXT,       16'h9999, 32'h9999_9999, 0, 0, 0, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // phases of the random part: wrap limit, buffer count, items
    // ------------------------------------------------------------------
    localparam int N_PHASES = 10;
    logic [WRAP_W-1:0] ph_wrap  [N_PHASES] = '{16'd3, 16'd65535, 16'd16, 16'd7, 16'd5,
                                               16'd0, 16'd2, 16'd65535, 16'd100, 16'd4};
    logic [BIU_W-1:0]  ph_count [N_PHASES] = '{4'd8, 4'd15, 4'd8, 4'd2, 4'd1,
                                               4'd0, 4'd3, 4'd8, 4'd6, 4'd9};
    int                ph_items [N_PHASES] = '{220, 200, 200, 200, 160,
                                               60, 140, 220, 200, 180};

    // main stimulus
    initial begin
        aresetn           <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= CFG_FRAME_WRAP;
        cfg_wr_data       <= '0;
        s_valid           <= 1'b0;
        s_opcode          <= OP_NEXT;
        s_requested_frame <= '0;
        s_config_tag_in   <= '0;
        reset_pool_model();
        build_script();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset settings
        foreach (opening_script[k])
            send_op(opening_script[k].op, opening_script[k].frame, opening_script[k].tag,
                    opening_script[k].typed, opening_script[k].want);
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            load_pool_cfg(ph_wrap[p], ph_count[p]);
            // one phase runs with no random breaks
            calm = (p == 1);
            run_pool_traffic(ph_items[p]);
            drain_results();
        end
        calm = 1'b0;

        // idle on to catch stray results
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("[stat_buffer_pool_manager] OK");
        end else begin
            $display("[stat_buffer_pool_manager] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls and one long hold-off
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_pending && results_seen >= 400) begin
                // long stall so the block backs up into its input
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                for (int c = 0; c < 300; c++) @(posedge aclk);
            end else begin
                m_ready <= !take_break();
                @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h/%0h",
                         $time, m_status, m_buffer_index, m_frame_tag, m_config_tag_out);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", want.status, m_status);
                check_field("buffer_index", want.index, m_buffer_index);
                check_field("frame_tag", want.frame, m_frame_tag);
                check_field("config_tag_out", want.ctag, m_config_tag_out);
            end
        end
    end

    // hang guard, many times the slowest legal run
    initial begin
        #5_000_000;
        $display("[stat_buffer_pool_manager] ERROR");
        $finish;
    end

endmodule
